FILE: rtl/core/dsc_pkg.sv
`default_nettype none

package dsc_pkg;

  // Field widths fixed by the register map and the pixel format.
  localparam int PIX_W   = 24;
  localparam int POS_W   = 10;
  localparam int DIM_W   = 11;
  localparam int PROG_W  = 9;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Sizes that cover the whole legal range of the module parameters.
  localparam int IX_W    = 12;
  localparam int DV_W    = 8;
  localparam int SUM_W   = DV_W + 8;
  localparam int Q_DEPTH = 4;

  localparam int DEF_MAX_WIDTH      = 1024;
  localparam int DEF_MAX_HEIGHT     = 1024;
  localparam int DEF_MAX_BOX_FACTOR = 5;

  localparam logic [PROG_W-1:0] PROG_FULL = PROG_W'(256);

  localparam logic [DIM_W-1:0] RST_SCREEN_W = DIM_W'(640);
  localparam logic [DIM_W-1:0] RST_SCREEN_H = DIM_W'(480);
  localparam logic [POS_W-1:0] RST_LEFT     = POS_W'(160);
  localparam logic [POS_W-1:0] RST_TOP      = POS_W'(120);
  localparam logic [DIM_W-1:0] RST_RECT_W   = DIM_W'(320);
  localparam logic [DIM_W-1:0] RST_RECT_H   = DIM_W'(240);

  typedef enum logic [2:0] {
    REG_SCREEN_W = 3'd0,
    REG_SCREEN_H = 3'd1,
    REG_LEFT     = 3'd2,
    REG_TOP      = 3'd3,
    REG_RECT_W   = 3'd4,
    REG_RECT_H   = 3'd5,
    REG_PROGRESS = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]  screen_width;
    logic [DIM_W-1:0]  screen_height;
    logic [POS_W-1:0]  rect_left;
    logic [POS_W-1:0]  rect_top;
    logic [DIM_W-1:0]  rect_width;
    logic [DIM_W-1:0]  rect_height;
    logic [PROG_W-1:0] progress;
  } cfg_t;

  typedef enum logic {
    OP_NEAR,
    OP_BOX
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             first;
    logic             last;
    logic             done;
    logic [IX_W-1:0]  ix;
    logic [DV_W-1:0]  dv;
    logic [POS_W-1:0] ox;
    logic [POS_W-1:0] oy;
    logic [PIX_W-1:0] pixel;
  } entry_t;

  typedef enum logic [2:0] {
    FE_RUN,
    FE_SPANX,
    FE_SPANY,
    FE_BOX,
    FE_DIV_GO,
    FE_DIV_WAIT,
    FE_DV
  } fe_state_t;

  typedef enum logic [1:0] {
    DIV_W,
    DIV_H,
    DIV_DDY
  } div_sel_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_READ,
    BE_ACC,
    BE_DIV,
    BE_OUT
  } be_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/dsc_if.sv
`default_nettype none

interface dsc_in_if;
  import dsc_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             frame_start;
  modport source (output valid, pixel_in, frame_start, input ready);
  modport sink   (input valid, pixel_in, frame_start, output ready);
endinterface

interface dsc_out_if;
  import dsc_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] dest_x;
  logic [POS_W-1:0] dest_y;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_done;
  modport source (output valid, dest_x, dest_y, pixel_out, frame_done, input ready);
  modport sink   (input valid, dest_x, dest_y, pixel_out, frame_done, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/frame_downscaler_box_or_nearest.sv
`default_nettype none

// Channel      Role     Handshake          Contents
// pixels_in    sink     valid/ready        pixel_in, frame_start
// pixels_out   source   valid/ready        dest_x, dest_y, pixel_out, frame_done
// apb          slave    psel/penable       seven registers at byte address 4*i
//
// The front takes one source pixel per cycle while the four-entry queue has room.
// A picked pixel passes the back through its idle and output states; in box mode
// each source pixel inside the rectangle passes the read and accumulate states for
// the read-modify-write of the line sums, and an output pixel also waits for the
// three averaging dividers, which run in parallel. A frame start is held while the
// geometry work runs.
// Reset is synchronous; pixels before the first frame start are taken and dropped.

module frame_downscaler_box_or_nearest #(
  parameter int MAX_WIDTH      = dsc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = dsc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_BOX_FACTOR = dsc_pkg::DEF_MAX_BOX_FACTOR
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  dsc_in_if.sink                           pixels_in,
  dsc_out_if.source                        pixels_out,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dsc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [dsc_pkg::DATA_W-1:0]  pwdata,
  output logic      [dsc_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);
  import dsc_pkg::*;

  cfg_t   cfg;
  logic   wr_en;
  logic   q_full, q_empty, q_push, q_pop;
  entry_t q_entry, q_head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= RST_SCREEN_W;
      cfg.screen_height <= RST_SCREEN_H;
      cfg.rect_left     <= RST_LEFT;
      cfg.rect_top      <= RST_TOP;
      cfg.rect_width    <= RST_RECT_W;
      cfg.rect_height   <= RST_RECT_H;
      cfg.progress      <= '0;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_SCREEN_W: cfg.screen_width  <= pwdata[DIM_W-1:0];
        REG_SCREEN_H: cfg.screen_height <= pwdata[DIM_W-1:0];
        REG_LEFT:     cfg.rect_left     <= pwdata[POS_W-1:0];
        REG_TOP:      cfg.rect_top      <= pwdata[POS_W-1:0];
        REG_RECT_W:   cfg.rect_width    <= pwdata[DIM_W-1:0];
        REG_RECT_H:   cfg.rect_height   <= pwdata[DIM_W-1:0];
        REG_PROGRESS: cfg.progress      <= pwdata[PROG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SCREEN_W: prdata = DATA_W'(cfg.screen_width);
      REG_SCREEN_H: prdata = DATA_W'(cfg.screen_height);
      REG_LEFT:     prdata = DATA_W'(cfg.rect_left);
      REG_TOP:      prdata = DATA_W'(cfg.rect_top);
      REG_RECT_W:   prdata = DATA_W'(cfg.rect_width);
      REG_RECT_H:   prdata = DATA_W'(cfg.rect_height);
      REG_PROGRESS: prdata = DATA_W'(cfg.progress);
      default:      prdata = '0;
    endcase
  end

  dsc_front #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .MAX_BOX_FACTOR (MAX_BOX_FACTOR)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pixels_in (pixels_in),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  dsc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_entry),
    .pop   (q_pop),
    .rdata (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  dsc_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .pixels_out (pixels_out)
  );

endmodule

`default_nettype wire

FILE: rtl/core/dsc_div.sv
`default_nettype none

module dsc_div #(
  parameter int N_W = 19,
  parameter int D_W = 11
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [N_W-1:0] dividend,
  input  wire logic [D_W-1:0] divisor,
  output logic                busy,
  output logic [N_W-1:0]      quot,
  output logic [D_W-1:0]      rem
);
  localparam int CW = $clog2(N_W + 1);

  logic [CW-1:0]  cnt;
  logic [N_W-1:0] q;
  logic [D_W-1:0] r;
  logic [D_W-1:0] d;
  logic [D_W:0]   trial;
  logic [D_W:0]   diff;
  logic           ge;

  // Restoring division, one quotient bit per cycle, MSB first.
  always_comb begin
    trial = {r, q[N_W-1]};
    diff  = trial - {1'b0, d};
    ge    = trial >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(N_W);
    end else if (cnt != '0) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (cnt != '0) begin
      q <= {q[N_W-2:0], ge};
      r <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
    end
  end

  assign busy = cnt != '0;
  assign quot = q;
  assign rem  = r;

endmodule

`default_nettype wire

FILE: rtl/core/dsc_fifo.sv
`default_nettype none

module dsc_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire dsc_pkg::entry_t wdata,
  input  wire logic            pop,
  output dsc_pkg::entry_t      rdata,
  output logic                 full,
  output logic                 empty
);
  import dsc_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  entry_t        slots [Q_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  assign full  = count == CW'(Q_DEPTH);
  assign empty = count == '0;
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PW'(1);
      end
      if (pop) begin
        rptr <= rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CW'(1)))
    else $error("queue fill count lost a transfer");

endmodule

`default_nettype wire

FILE: rtl/core/dsc_front.sv
`default_nettype none

module dsc_front #(
  parameter int MAX_WIDTH      = dsc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = dsc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_BOX_FACTOR = dsc_pkg::DEF_MAX_BOX_FACTOR
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire dsc_pkg::cfg_t cfg,
  dsc_in_if.sink             pixels_in,
  input  wire logic          q_full,
  output logic               q_push,
  output dsc_pkg::entry_t    q_entry
);
  import dsc_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);
  localparam int DW = (XW > YW) ? XW : YW;
  localparam int EW = ((DW > DIM_W) ? DW : DIM_W) + 1;
  localparam int RW = $clog2(MAX_HEIGHT * 256 + 1);
  localparam int NW = DW + 8;

  typedef struct packed {
    logic [EW-1:0] start;
    logic [EW-1:0] size;
  } span_t;

  // Clamp the rectangle to the screen, then widen it toward the full screen.
  function automatic span_t span(input logic [EW-1:0] full, input logic [EW-1:0] org,
                                 input logic [EW-1:0] len, input logic [PROG_W-1:0] ml);
    logic [EW-1:0]   a;
    logic [EW-1:0]   lim;
    logic [EW-1:0]   l;
    logic [EW-1:0]   b;
    logic [EW+8:0]   pa;
    logic [EW+8:0]   pb;
    span_t           s;
    a   = (org >= full) ? full - EW'(1) : org;
    lim = full - a;
    l   = (len > lim) ? lim : len;
    if (l == '0) begin
      l = EW'(1);
    end
    b   = a + l;
    pa  = (EW+9)'(a) * (EW+9)'(ml);
    pb  = (EW+9)'(full - b) * (EW+9)'(ml);
    s.start = a - EW'(pa >> 8);
    s.size  = b + EW'(pb >> 8) - s.start;
    return s;
  endfunction

  fe_state_t   state, state_next;
  div_sel_t    div_idx;
  logic        geo_valid;
  logic        fresh;

  logic [DW-1:0]     gw, gh, start_x, start_y, sx, sy, fx, rx, fy;
  logic [RW-1:0]     ddy;
  logic [DV_W-1:0]   dv;
  logic              box;
  logic [PROG_W-1:0] ml;

  logic [DW-1:0] col, row, dcol, drow, tq, trem, cx, bx, ry, by;
  logic [RW-1:0] racc;

  logic            div_start, div_busy;
  logic [NW-1:0]   div_n, div_q;
  logic [DW-1:0]   div_d, div_r;

  logic            accept, active, box_in, near_row, near_pick, row_end;
  logic [EW-1:0]   w_cl, h_cl;
  span_t           sp;
  logic            box_hit;
  logic [DW+3:0]   px, py;
  logic [DW:0]     tsum;
  logic [2*DW-1:0] dv_prod;

  dsc_div #(.N_W(NW), .D_W(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .quot     (div_q),
    .rem      (div_r)
  );

  always_comb begin
    w_cl = EW'(cfg.screen_width);
    if (w_cl == '0) begin
      w_cl = EW'(1);
    end else if (w_cl > EW'(MAX_WIDTH)) begin
      w_cl = EW'(MAX_WIDTH);
    end
    h_cl = EW'(cfg.screen_height);
    if (h_cl == '0) begin
      h_cl = EW'(1);
    end else if (h_cl > EW'(MAX_HEIGHT)) begin
      h_cl = EW'(MAX_HEIGHT);
    end
  end

  always_comb begin
    if (state == FE_SPANX) begin
      sp = span(EW'(gw), EW'(cfg.rect_left), EW'(cfg.rect_width), ml);
    end else begin
      sp = span(EW'(gh), EW'(cfg.rect_top), EW'(cfg.rect_height), ml);
    end
  end

  // Box mode holds when the size is the screen size over some factor from 2 to MAX_BOX_FACTOR, rounded down.
  always_comb begin
    box_hit = 1'b0;
    px      = '0;
    py      = '0;
    for (int b = 2; b <= MAX_BOX_FACTOR; b++) begin
      px = (DW+4)'(sx) * (DW+4)'(b);
      py = (DW+4)'(sy) * (DW+4)'(b);
      if (px <= (DW+4)'(gw) && ((DW+4)'(gw) - px) < (DW+4)'(b) &&
          py <= (DW+4)'(gh) && ((DW+4)'(gh) - py) < (DW+4)'(b)) begin
        box_hit = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (div_idx)
      DIV_W: begin
        div_n = NW'(gw);
        div_d = sx;
      end
      DIV_H: begin
        div_n = NW'(gh);
        div_d = sy;
      end
      DIV_DDY: begin
        div_n = {gh, 8'b0};
        div_d = sy;
      end
      default: begin
        div_n = NW'(gw);
        div_d = sx;
      end
    endcase
  end

  assign dv_prod = {{DW{1'b0}}, fx} * {{DW{1'b0}}, fy};

  always_comb begin
    pixels_in.ready = (state == FE_RUN) && !q_full && (!pixels_in.frame_start || fresh);
    accept    = pixels_in.valid && pixels_in.ready;
    active    = accept && geo_valid && (row < gh);
    box_in    = (bx < sx) && (by < sy);
    near_row  = (drow < sy) && (RW'(row) == (racc >> 8));
    near_pick = near_row && (dcol < sx) && (col == tq);
    row_end   = col == gw - DW'(1);
    tsum      = {1'b0, trem} + {1'b0, rx};
    q_push    = active && (box ? box_in : near_pick);

    q_entry.op    = box ? OP_BOX : OP_NEAR;
    q_entry.first = (cx == '0) && (ry == '0);
    q_entry.last  = (cx == fx - DW'(1)) && (ry == fy - DW'(1));
    q_entry.ix    = IX_W'(bx);
    q_entry.dv    = dv;
    q_entry.pixel = pixels_in.pixel_in;
    if (box) begin
      q_entry.ox   = POS_W'({1'b0, start_x} + {1'b0, bx});
      q_entry.oy   = POS_W'({1'b0, start_y} + {1'b0, by});
      q_entry.done = (bx == sx - DW'(1)) && (by == sy - DW'(1));
    end else begin
      q_entry.ox   = POS_W'({1'b0, start_x} + {1'b0, dcol});
      q_entry.oy   = POS_W'({1'b0, start_y} + {1'b0, drow});
      q_entry.done = (drow == sy - DW'(1)) && (dcol == sx - DW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      FE_RUN: begin
        if (pixels_in.valid && pixels_in.frame_start && !fresh) begin
          state_next = FE_SPANX;
        end
      end
      FE_SPANX: state_next = FE_SPANY;
      FE_SPANY: state_next = FE_BOX;
      FE_BOX:   state_next = FE_DIV_GO;
      FE_DIV_GO: begin
        div_start  = 1'b1;
        state_next = FE_DIV_WAIT;
      end
      FE_DIV_WAIT: begin
        if (!div_busy) begin
          state_next = (div_idx == DIV_DDY) ? FE_DV : FE_DIV_GO;
        end
      end
      FE_DV: state_next = FE_RUN;
      default: state_next = FE_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      geo_valid <= 1'b0;
      fresh     <= 1'b0;
      div_idx   <= DIV_W;
    end else begin
      if (state == FE_BOX) begin
        div_idx <= DIV_W;
      end else if (state == FE_DIV_WAIT && !div_busy) begin
        unique case (div_idx)
          DIV_W:   div_idx <= DIV_H;
          DIV_H:   div_idx <= DIV_DDY;
          default: div_idx <= DIV_W;
        endcase
      end
      if (state == FE_DV) begin
        geo_valid <= 1'b1;
        fresh     <= 1'b1;
      end else if (accept) begin
        fresh <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      FE_RUN: begin
        if (pixels_in.valid && pixels_in.frame_start && !fresh) begin
          gw <= DW'(w_cl);
          gh <= DW'(h_cl);
          ml <= (cfg.progress > PROG_FULL) ? PROG_FULL : cfg.progress;
        end
        if (active) begin
          if (!box && near_row) begin
            if (near_pick) begin
              dcol <= dcol + DW'(1);
              if (tsum >= {1'b0, sx}) begin
                trem <= DW'(tsum - {1'b0, sx});
                tq   <= tq + fx + DW'(1);
              end else begin
                trem <= DW'(tsum);
                tq   <= tq + fx;
              end
            end
            if (row_end) begin
              drow <= drow + DW'(1);
              racc <= racc + ddy;
              dcol <= '0;
              tq   <= '0;
              trem <= '0;
            end
          end
          if (row_end) begin
            col <= '0;
            row <= row + DW'(1);
            cx  <= '0;
            bx  <= '0;
            if (ry == fy - DW'(1)) begin
              ry <= '0;
              by <= by + DW'(1);
            end else begin
              ry <= ry + DW'(1);
            end
          end else begin
            col <= col + DW'(1);
            if (cx == fx - DW'(1)) begin
              cx <= '0;
              bx <= bx + DW'(1);
            end else begin
              cx <= cx + DW'(1);
            end
          end
        end
      end
      FE_SPANX: begin
        start_x <= DW'(sp.start);
        sx      <= DW'(sp.size);
      end
      FE_SPANY: begin
        start_y <= DW'(sp.start);
        sy      <= DW'(sp.size);
      end
      FE_BOX: box <= box_hit;
      FE_DIV_GO: ;
      FE_DIV_WAIT: begin
        if (!div_busy) begin
          unique case (div_idx)
            DIV_W: begin
              fx <= DW'(div_q);
              rx <= div_r;
            end
            DIV_H:   fy  <= DW'(div_q);
            default: ddy <= RW'(div_q);
          endcase
        end
      end
      FE_DV: begin
        dv   <= dv_prod[DV_W-1:0];
        col  <= '0;
        row  <= '0;
        dcol <= '0;
        drow <= '0;
        tq   <= '0;
        trem <= '0;
        racc <= '0;
        cx   <= '0;
        bx   <= '0;
        ry   <= '0;
        by   <= '0;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/dsc_back.sv
`default_nettype none

module dsc_back #(
  parameter int MAX_WIDTH = dsc_pkg::DEF_MAX_WIDTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_empty,
  input  wire dsc_pkg::entry_t q_head,
  output logic                 q_pop,
  dsc_out_if.source            pixels_out
);
  import dsc_pkg::*;

  localparam int IXW = $clog2(MAX_WIDTH);

  be_state_t state, state_next;
  entry_t    cur;

  logic [3*SUM_W-1:0] mem [MAX_WIDTH];
  logic [3*SUM_W-1:0] rd_word;
  logic [3*SUM_W-1:0] wr_word;
  logic [SUM_W-1:0]   sum_r, sum_g, sum_b;
  logic [IXW-1:0]     addr;

  logic               div_start;
  logic               busy_r, busy_g, busy_b;
  logic [SUM_W-1:0]   q_r, q_g, q_b;
  logic [DV_W-1:0]    rem_r, rem_g, rem_b;

  logic               ovalid;
  logic [POS_W-1:0]   ox, oy;
  logic [PIX_W-1:0]   opix;
  logic               odone;
  logic               out_free;

  assign addr     = cur.ix[IXW-1:0];
  assign out_free = !ovalid || pixels_out.ready;

  // The first pixel of a block starts its sums over; stale words are read but not used.
  always_comb begin
    if (cur.first) begin
      sum_r = SUM_W'(cur.pixel[23:16]);
      sum_g = SUM_W'(cur.pixel[15:8]);
      sum_b = SUM_W'(cur.pixel[7:0]);
    end else begin
      sum_r = rd_word[3*SUM_W-1:2*SUM_W] + SUM_W'(cur.pixel[23:16]);
      sum_g = rd_word[2*SUM_W-1:SUM_W] + SUM_W'(cur.pixel[15:8]);
      sum_b = rd_word[SUM_W-1:0] + SUM_W'(cur.pixel[7:0]);
    end
    wr_word = {sum_r, sum_g, sum_b};
  end

  dsc_div #(.N_W(SUM_W), .D_W(DV_W)) u_div_r (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum_r), .divisor(cur.dv),
    .busy(busy_r), .quot(q_r), .rem(rem_r)
  );
  dsc_div #(.N_W(SUM_W), .D_W(DV_W)) u_div_g (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum_g), .divisor(cur.dv),
    .busy(busy_g), .quot(q_g), .rem(rem_g)
  );
  dsc_div #(.N_W(SUM_W), .D_W(DV_W)) u_div_b (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum_b), .divisor(cur.dv),
    .busy(busy_b), .quot(q_b), .rem(rem_b)
  );

  always_ff @(posedge clk) begin
    if (state == BE_READ) begin
      rd_word <= mem[addr];
    end
    if (state == BE_ACC) begin
      mem[addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      BE_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = (q_head.op == OP_BOX) ? BE_READ : BE_OUT;
        end
      end
      BE_READ: state_next = BE_ACC;
      BE_ACC: begin
        if (cur.last) begin
          div_start  = 1'b1;
          state_next = BE_DIV;
        end else begin
          state_next = BE_IDLE;
        end
      end
      BE_DIV: begin
        if (!(busy_r || busy_g || busy_b)) begin
          state_next = BE_OUT;
        end
      end
      BE_OUT: begin
        if (out_free) begin
          state_next = BE_IDLE;
        end
      end
      default: state_next = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == BE_IDLE && !q_empty) begin
      cur <= q_head;
    end else if (state == BE_DIV && !(busy_r || busy_g || busy_b)) begin
      cur.pixel <= {q_r[7:0], q_g[7:0], q_b[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (state == BE_OUT && out_free) begin
      ovalid <= 1'b1;
    end else if (pixels_out.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BE_OUT && out_free) begin
      ox    <= cur.ox;
      oy    <= cur.oy;
      opix  <= cur.pixel;
      odone <= cur.done;
    end
  end

  assign pixels_out.valid      = ovalid;
  assign pixels_out.dest_x     = ox;
  assign pixels_out.dest_y     = oy;
  assign pixels_out.pixel_out  = opix;
  assign pixels_out.frame_done = odone;

endmodule

`default_nettype wire
